/* rtl/tss_pkg.sv */
// Shared types and constants of the triangle sweep sequencer.
// No dependencies.
package tss_pkg;

  localparam int CHAN_BITS    = 4;
  localparam int MODE_BITS    = 2;
  localparam int ACT_BITS     = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int RES_DEPTH    = 8;
  localparam int RES_PER_ITEM = 3;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_FLUSH  = 2'd3
  } action_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HIGH   = 2'd1,
    MODE_HIGHER = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_BOUND = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_BOUND = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_DELAY  = 2'd3;

  localparam logic [0:0] REQ_TICK  = 1'b0;
  localparam logic [0:0] REQ_START = 1'b1;

  typedef struct packed {
    logic [1:0] cnt;
  } push_ctl_t;

endpackage

/* rtl/tss_result_fifo.sv */
// Result queue: takes up to three entries per cycle, hands out one per transfer.
// Depends on tss_pkg. DEPTH must be a power of two, at least four.
module tss_result_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tss_pkg::push_ctl_t  push_ctl,
  input  logic [WIDTH-1:0]    push_data [tss_pkg::RES_PER_ITEM],
  output logic                room,
  output logic                pop_valid,
  input  logic                pop_ready,
  output logic [WIDTH-1:0]    pop_data
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wptr_r, wptr_nxt;
  logic [PTR_BITS-1:0] rptr_r, rptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rptr_r];
  assign room      = (cnt_r <= CNT_BITS'(DEPTH - tss_pkg::RES_PER_ITEM));

  always_comb begin
    wptr_nxt = wptr_r + PTR_BITS'(push_ctl.cnt);
    rptr_nxt = pop ? rptr_r + PTR_BITS'(1) : rptr_r;
    cnt_nxt  = cnt_r + CNT_BITS'(push_ctl.cnt) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tss_pkg::RES_PER_ITEM; k++) begin
      if (k < int'(push_ctl.cnt)) begin
        mem_r[wptr_r + PTR_BITS'(k)] <= push_data[k];
      end
    end
  end

endmodule

/* rtl/triangle_sweep_sequencer.sv */
// Triangle sweep sequencer: start and tick items in, DAC writes and markers out.
// Depends on tss_pkg and tss_result_fifo.
//
//  channel | ports                         | transfer when
//  in      | in_valid/in_ready, in_*       | in_valid && in_ready
//  out     | out_valid/out_ready, out_*    | out_valid && out_ready
//  cfg     | cfg_valid/cfg_ready, cfg_*    | cfg_valid && cfg_ready
//
// One item is taken per cycle while the result queue has room for three
// results; the queue drains one result per cycle while out_ready is high.
// The sweep state updates in the cycle the item transfers; results are registered
// in the result queue before they appear on out_*.
// Synchronous active-low reset clears the sweep state, registers and queue.
// cfg_ready is always high.
module triangle_sweep_sequencer #(
  parameter int VALUE_BITS = 24,
  parameter int DELAY_BITS = 24,
  parameter int STEP_BITS  = 16,
  localparam int CFG_BITS  = (VALUE_BITS > DELAY_BITS)
                             ? ((VALUE_BITS > STEP_BITS) ? VALUE_BITS : STEP_BITS)
                             : ((DELAY_BITS > STEP_BITS) ? DELAY_BITS : STEP_BITS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic                              in_read_forward,
  input  logic                              in_read_backward,
  input  logic                              in_high_res,
  input  logic                              in_higher_res,
  input  logic [tss_pkg::CHAN_BITS-1:0]     in_channel_sel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tss_pkg::ACT_BITS-1:0]      out_action,
  output logic [VALUE_BITS-1:0]             out_value,
  output logic [tss_pkg::CHAN_BITS-1:0]     out_channel,
  output logic [tss_pkg::MODE_BITS-1:0]     out_res_mode,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]               cfg_data
);

  localparam int ENTRY_BITS = tss_pkg::ACT_BITS + VALUE_BITS + tss_pkg::CHAN_BITS
                              + tss_pkg::MODE_BITS + 1;
  localparam int SUM_BITS   = ((VALUE_BITS > STEP_BITS) ? VALUE_BITS : STEP_BITS) + 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_UP,
    PH_TURN,
    PH_DOWN
  } phase_t;

  logic [VALUE_BITS-1:0] lower_r, upper_r;
  logic [STEP_BITS-1:0]  step_r;
  logic [DELAY_BITS-1:0] delay_r;

  phase_t                          phase_r, phase_nxt;
  logic [VALUE_BITS-1:0]           cv_r, cv_nxt;
  logic [DELAY_BITS-1:0]           wait_r, wait_nxt;
  logic [STEP_BITS-1:0]            sub_r, sub_nxt;
  logic [1:0]                      flags_r, flags_nxt;
  logic [tss_pkg::MODE_BITS-1:0]   mode_r, mode_nxt;
  logic [tss_pkg::CHAN_BITS-1:0]   chan_r, chan_nxt;

  logic                  accept;
  logic                  paced;
  logic [VALUE_BITS-1:0] cv_step;
  logic [STEP_BITS-1:0]  sub_inc;
  logic                  full;
  logic                  fits_start, fits_up;
  logic                  room;

  tss_pkg::action_t      act [tss_pkg::RES_PER_ITEM];
  logic [VALUE_BITS-1:0] val [tss_pkg::RES_PER_ITEM];
  tss_pkg::push_ctl_t    push_ctl;
  logic [ENTRY_BITS-1:0] push_data [tss_pkg::RES_PER_ITEM];
  logic [ENTRY_BITS-1:0] pop_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign accept    = in_valid && in_ready;

  assign paced   = (wait_r >= delay_r);
  assign cv_step = (phase_r == PH_UP) ? cv_r + VALUE_BITS'(1) : cv_r - VALUE_BITS'(1);
  assign sub_inc = sub_r + STEP_BITS'(1);
  assign full    = (sub_inc >= step_r);

  assign fits_start = (step_r != '0) &&
                      (SUM_BITS'(lower_r) + SUM_BITS'(step_r) <= SUM_BITS'(upper_r));
  assign fits_up    = (step_r != '0) &&
                      (SUM_BITS'(cv_step) + SUM_BITS'(step_r) <= SUM_BITS'(upper_r));

  always_comb begin
    phase_nxt    = phase_r;
    cv_nxt       = cv_r;
    wait_nxt     = wait_r;
    sub_nxt      = sub_r;
    flags_nxt    = flags_r;
    mode_nxt     = mode_r;
    chan_nxt     = chan_r;
    push_ctl.cnt = 2'd0;
    for (int k = 0; k < tss_pkg::RES_PER_ITEM; k++) begin
      act[k] = tss_pkg::ACT_WRITE;
      val[k] = cv_r;
    end

    if (accept) begin
      if (in_req_type == tss_pkg::REQ_START) begin
        flags_nxt    = {in_read_backward, in_read_forward};
        mode_nxt     = in_higher_res ? tss_pkg::MODE_HIGHER
                     : (in_high_res ? tss_pkg::MODE_HIGH : tss_pkg::MODE_NORMAL);
        chan_nxt     = in_channel_sel;
        cv_nxt       = lower_r;
        wait_nxt     = '0;
        sub_nxt      = '0;
        val[0]       = lower_r;
        val[1]       = lower_r;
        act[1]       = in_read_forward ? tss_pkg::ACT_READ : tss_pkg::ACT_UPDATE;
        push_ctl.cnt = 2'd2;
        phase_nxt    = fits_start ? PH_UP : PH_TURN;
      end else begin
        case (phase_r)
          PH_UP, PH_DOWN: begin
            if (!paced) begin
              wait_nxt = wait_r + DELAY_BITS'(1);
            end else begin
              wait_nxt     = '0;
              cv_nxt       = cv_step;
              sub_nxt      = sub_inc;
              val[0]       = cv_step;
              val[1]       = cv_step;
              val[2]       = cv_step;
              push_ctl.cnt = 2'd1;
              if (full) begin
                sub_nxt      = '0;
                push_ctl.cnt = 2'd2;
                if (phase_r == PH_UP) begin
                  act[1] = flags_r[0] ? tss_pkg::ACT_READ : tss_pkg::ACT_UPDATE;
                  if (!fits_up) begin
                    phase_nxt = PH_TURN;
                  end
                end else begin
                  act[1] = flags_r[1] ? tss_pkg::ACT_READ : tss_pkg::ACT_UPDATE;
                  if (cv_step <= lower_r) begin
                    act[2]       = tss_pkg::ACT_FLUSH;
                    push_ctl.cnt = 2'd3;
                    phase_nxt    = PH_IDLE;
                  end
                end
              end
            end
          end
          PH_TURN: begin
            if (!paced) begin
              wait_nxt = wait_r + DELAY_BITS'(1);
            end else begin
              wait_nxt     = '0;
              sub_nxt      = '0;
              act[1]       = flags_r[1] ? tss_pkg::ACT_READ : tss_pkg::ACT_UPDATE;
              push_ctl.cnt = 2'd2;
              if ((step_r != '0) && (cv_r > lower_r)) begin
                phase_nxt = PH_DOWN;
              end else begin
                act[2]       = tss_pkg::ACT_FLUSH;
                push_ctl.cnt = 2'd3;
                phase_nxt    = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    for (int k = 0; k < tss_pkg::RES_PER_ITEM; k++) begin
      push_data[k] = {act[k], val[k], chan_nxt, mode_nxt,
                      (k == int'(push_ctl.cnt) - 1)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
      step_r  <= '0;
      delay_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tss_pkg::REG_LOWER_BOUND: lower_r <= cfg_data[VALUE_BITS-1:0];
        tss_pkg::REG_UPPER_BOUND: upper_r <= cfg_data[VALUE_BITS-1:0];
        tss_pkg::REG_STEP_SIZE:   step_r  <= cfg_data[STEP_BITS-1:0];
        tss_pkg::REG_MOVE_DELAY:  delay_r <= cfg_data[DELAY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cv_r    <= '0;
      wait_r  <= '0;
      sub_r   <= '0;
      flags_r <= '0;
      mode_r  <= '0;
      chan_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cv_r    <= cv_nxt;
      wait_r  <= wait_nxt;
      sub_r   <= sub_nxt;
      flags_r <= flags_nxt;
      mode_r  <= mode_nxt;
      chan_r  <= chan_nxt;
    end
  end

  tss_result_fifo #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (tss_pkg::RES_DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_ctl  (push_ctl),
    .push_data (push_data),
    .room      (room),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (pop_data)
  );

  assign {out_action, out_value, out_channel, out_res_mode, out_last} = pop_data;

endmodule

/* tb/sweep_check_pkg.sv */
`timescale 1ns / 100ps
// Sweep scoreboard: predicts the DAC writes, read/update markers and flushes that
// each accepted start or tick causes, and checks every result transfer in order.
// Depends on tss_pkg.
package sweep_check_pkg;
  import tss_pkg::*;

  localparam logic [1:0] FLAG_FWD = 2'b01;
  localparam logic [1:0] FLAG_BWD = 2'b10;

  typedef struct {
    action_t     act;
    logic [23:0] value;
    logic [3:0]  chan;
    mode_t       mode;
    logic        last;
  } sweep_out_t;

  typedef enum logic [1:0] {
    SWP_IDLE,
    SWP_UP,
    SWP_TURN,
    SWP_DOWN
  } sweep_phase_t;

  class sweep_scoreboard;
    logic [23:0]  lower;
    logic [23:0]  upper;
    logic [15:0]  step;
    logic [23:0]  pace_ticks;
    sweep_phase_t phase;
    logic [23:0]  level;
    logic [23:0]  wait_cnt;
    logic [15:0]  substep;
    logic [1:0]   read_flags;
    mode_t        mode;
    logic [3:0]   chan;
    sweep_out_t   outputs_due[$];
    int           errors;
    int           checked;
    int           starts;

    function new();
      lower      = '0;
      upper      = '0;
      step       = '0;
      pace_ticks = '0;
      phase      = SWP_IDLE;
      level      = '0;
      wait_cnt   = '0;
      substep    = '0;
      read_flags = '0;
      mode       = MODE_NORMAL;
      chan       = '0;
      errors     = 0;
      checked    = 0;
      starts     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        REG_LOWER_BOUND: lower = data;
        REG_UPPER_BOUND: upper = data;
        REG_STEP_SIZE:   step = data[15:0];
        REG_MOVE_DELAY:  pace_ticks = data;
        default: ;
      endcase
    endfunction

    function void emit(action_t act);
      sweep_out_t r;
      r.act   = act;
      r.value = level;
      r.chan  = chan;
      r.mode  = mode;
      r.last  = 1'b0;
      outputs_due.push_back(r);
    endfunction

    function void mark(logic [1:0] flag);
      emit(((read_flags & flag) != 2'b00) ? ACT_READ : ACT_UPDATE);
    endfunction

    function bit step_fits();
      return (step != 16'd0) && (({1'b0, level} + {9'd0, step}) <= {1'b0, upper});
    endfunction

    function bit paced();
      if (wait_cnt < pace_ticks) begin
        wait_cnt = wait_cnt + 1'b1;
        return 1'b0;
      end
      wait_cnt = '0;
      return 1'b1;
    endfunction

    // Returns 0 for a tick that the idle block drops.
    function bit take_item(logic req, logic rf, logic rb, logic hr, logic hrr,
                           logic [3:0] ch);
      int         n_before;
      bit         live;
      sweep_out_t r;
      n_before = outputs_due.size();
      live = 1'b1;
      if (req == REQ_START) begin
        starts++;
        read_flags = {rb, rf};
        mode = hrr ? MODE_HIGHER : (hr ? MODE_HIGH : MODE_NORMAL);
        chan = ch;
        level = lower;
        wait_cnt = '0;
        substep = '0;
        emit(ACT_WRITE);
        mark(FLAG_FWD);
        phase = step_fits() ? SWP_UP : SWP_TURN;
      end else if (phase == SWP_UP || phase == SWP_DOWN) begin
        if (paced()) begin
          level = (phase == SWP_UP) ? level + 1'b1 : level - 1'b1;
          substep = substep + 1'b1;
          emit(ACT_WRITE);
          if (substep >= step) begin
            substep = '0;
            if (phase == SWP_UP) begin
              mark(FLAG_FWD);
              if (!step_fits()) phase = SWP_TURN;
            end else begin
              mark(FLAG_BWD);
              if (level <= lower) begin
                emit(ACT_FLUSH);
                phase = SWP_IDLE;
              end
            end
          end
        end
      end else if (phase == SWP_TURN) begin
        if (paced()) begin
          substep = '0;
          emit(ACT_WRITE);
          mark(FLAG_BWD);
          if (step != 16'd0 && level > lower) begin
            phase = SWP_DOWN;
          end else begin
            emit(ACT_FLUSH);
            phase = SWP_IDLE;
          end
        end
      end else begin
        live = 1'b0;
      end
      if (outputs_due.size() > n_before) begin
        r = outputs_due.pop_back();
        r.last = 1'b1;
        outputs_due.push_back(r);
      end
      return live;
    endfunction

    function void match_output(logic [1:0] act, logic [23:0] value, logic [3:0] ch,
                               logic [1:0] md, logic last);
      sweep_out_t e;
      checked++;
      if (outputs_due.size() == 0) begin
        $display("%0t: unexpected result, action %0d value %0d", $time, act, value);
        errors++;
        return;
      end
      e = outputs_due.pop_front();
      if (act !== e.act) begin
        $display("%0t: action mismatch, expected %0d actual %0d", $time, e.act, act);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: value mismatch, expected %0d actual %0d", $time, e.value, value);
        errors++;
      end
      if (ch !== e.chan) begin
        $display("%0t: channel mismatch, expected %0d actual %0d", $time, e.chan, ch);
        errors++;
      end
      if (md !== e.mode) begin
        $display("%0t: res_mode mismatch, expected %0d actual %0d", $time, e.mode, md);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch, expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the triangle sweep sequencer testbench: directed and random start/tick
// traffic with random stalls on both channels, register writes between phases.
// Depends on tss_pkg, sweep_check_pkg and triangle_sweep_sequencer.
module testbench;
  import tss_pkg::*;
  import sweep_check_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEM_TOTAL   = 230;

  localparam logic [3:0] CFG_ALL        = 4'b1111;
  localparam logic [3:0] CFG_NO_STEP    = 4'b1011;
  localparam logic [3:0] CFG_DELAY_ONLY = 4'b1000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic        in_read_forward;
  logic        in_read_backward;
  logic        in_high_res;
  logic        in_higher_res;
  logic [3:0]  in_channel_sel;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_action;
  logic [23:0] out_value;
  logic [3:0]  out_channel;
  logic [1:0]  out_res_mode;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  sweep_scoreboard sb;
  int cycles = 0;
  int tx_max = 0;
  int rx_max = 0;
  int rx_gap;
  int rx_draw;
  int hold_req = 0;
  int hold_ack;
  int hold_left;
  int live_items = 0;
  int items_sent = 0;

  triangle_sweep_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_read_forward  (in_read_forward),
    .in_read_backward (in_read_backward),
    .in_high_res      (in_high_res),
    .in_higher_res    (in_higher_res),
    .in_channel_sel   (in_channel_sel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_value        (out_value),
    .out_channel      (out_channel),
    .out_res_mode     (out_res_mode),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_draw = $urandom_range(0, rx_max);
      out_ready <= (rx_draw == 0);
      if (rx_draw != 0) rx_gap <= rx_draw - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        if (sb.take_item(in_req_type, in_read_forward, in_read_backward, in_high_res,
                         in_higher_res, in_channel_sel))
          live_items++;
      end
      if (out_valid && out_ready)
        sb.match_output(out_action, out_value, out_channel, out_res_mode, out_last);
    end
  end

  task automatic send_item(logic req, logic rf, logic rb, logic hr, logic hrr,
                           logic [3:0] ch);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_read_forward  <= rf;
    in_read_backward <= rb;
    in_high_res      <= hr;
    in_higher_res    <= hrr;
    in_channel_sel   <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)));
  endtask

  task automatic send_start();
    send_item(REQ_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)));
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (sb.outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_regs(logic [3:0] mask, logic [23:0] lo, logic [23:0] hi,
                            logic [15:0] st, logic [23:0] dl);
    if (mask[0]) put_reg(REG_LOWER_BOUND, lo);
    if (mask[1]) put_reg(REG_UPPER_BOUND, hi);
    if (mask[2]) put_reg(REG_STEP_SIZE, {8'd0, st});
    if (mask[3]) put_reg(REG_MOVE_DELAY, dl);
  endtask

  task automatic new_sweep_config();
    logic [23:0] lo;
    logic [23:0] hi;
    logic [15:0] st;
    logic [23:0] dl;
    int          pick;
    int          span;
    pick = $urandom_range(0, 9);
    if (pick == 0) lo = '0;
    else if (pick == 1) lo = 24'hFFFFFF - 24'($urandom_range(0, 12));
    else lo = 24'($urandom);
    pick = $urandom_range(0, 9);
    span = $urandom_range(0, 16);
    if (pick == 0) hi = (lo == 24'd0) ? 24'd0 : lo - 1'b1;
    else if (lo > 24'hFFFFFF - 24'(span)) hi = 24'hFFFFFF;
    else hi = lo + 24'(span);
    pick = $urandom_range(0, 9);
    if (pick == 0) st = '0;
    else if (pick == 1) st = 16'hFFFF;
    else st = 16'($urandom_range(1, 4));
    pick = $urandom_range(0, 14);
    if (pick == 0) dl = 24'hFFFFFF;
    else if (pick < 4) dl = 24'($urandom_range(1, 2));
    else dl = '0;
    write_regs(CFG_ALL, lo, hi, st, dl);
  endtask

  // Raise the lower bound, never lower it, so a running down pass never wraps below zero.
  task automatic adjust_sweep_config();
    logic [3:0]  mask;
    logic [23:0] lo;
    logic [23:0] hi;
    int          bump;
    mask = 4'($urandom_range(1, 15)) & CFG_NO_STEP;
    if (mask == 4'b0000) mask = CFG_DELAY_ONLY;
    bump = $urandom_range(0, 3);
    lo = (sb.lower > 24'hFFFFFF - 24'(bump)) ? 24'hFFFFFF : sb.lower + 24'(bump);
    bump = $urandom_range(0, 6);
    if ($urandom_range(0, 1) == 1)
      hi = (sb.upper > 24'hFFFFFF - 24'(bump)) ? 24'hFFFFFF : sb.upper + 24'(bump);
    else
      hi = (sb.upper < 24'(bump)) ? 24'd0 : sb.upper - 24'(bump);
    write_regs(mask, lo, hi, sb.step, 24'($urandom_range(0, 2)));
  endtask

  initial begin
    int burst;
    sb = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = 1'b0;
    in_read_forward  = 1'b0;
    in_read_backward = 1'b0;
    in_high_res      = 1'b0;
    in_higher_res    = 1'b0;
    in_channel_sel   = '0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, then a zero-step sweep with all registers at reset
    send_tick();
    send_tick();
    send_item(REQ_START, 1'b1, 1'b1, 1'b1, 1'b1, 4'hF);
    send_item(REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0);
    stop_input();
    wait_drain();

    write_regs(CFG_ALL, 24'd10, 24'd13, 16'd1, 24'd0);
    send_item(REQ_START, 1'b0, 1'b1, 1'b1, 1'b0, 4'h0);
    repeat (7) send_item(REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 4'hF);
    stop_input();
    wait_drain();

    // top of the value range with paced changes
    write_regs(CFG_ALL, 24'hFFFFFE, 24'hFFFFFF, 16'd1, 24'd1);
    send_item(REQ_START, 1'b1, 1'b0, 1'b0, 1'b0, 4'hA);
    repeat (6) send_tick();
    stop_input();
    wait_drain();

    // upper below lower, widest step and delay, restart while turning
    write_regs(CFG_ALL, 24'd100, 24'd50, 16'hFFFF, 24'hFFFFFF);
    send_item(REQ_START, 1'b1, 1'b0, 1'b1, 1'b0, 4'h3);
    send_tick();
    send_item(REQ_START, 1'b0, 1'b1, 1'b0, 1'b1, 4'hC);
    stop_input();
    wait_drain();
    write_regs(CFG_DELAY_ONLY, 24'd0, 24'd0, 16'd0, 24'd0);
    send_tick();
    stop_input();
    wait_drain();

    // long output stall while ticks keep coming
    write_regs(CFG_ALL, 24'd1000, 24'd1040, 16'd2, 24'd0);
    hold_req <= hold_req + 1;
    send_start();
    repeat (40) send_tick();
    stop_input();
    wait_drain();

    while (items_sent < ITEM_TOTAL) begin
      tx_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      rx_max <= ($urandom_range(0, 2) == 0) ? 0 : 10;
      if (sb.phase == SWP_IDLE || sb.pace_ticks > 24'd16 || $urandom_range(0, 5) == 0) begin
        new_sweep_config();
        send_start();
      end else if ($urandom_range(0, 2) == 0) begin
        adjust_sweep_config();
      end
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if ($urandom_range(0, 19) == 0) send_start();
        else send_tick();
      end
      stop_input();
      wait_drain();
    end

    if (sb.outputs_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.outputs_due.size());
      sb.errors++;
    end
    $display("Ran %0d input transfers (%0d sweep starts, %0d outside idle); %0d results checked",
             items_sent, sb.starts, live_items, sb.checked);
    $display("Covered zero-step, wrapped-range, paced, restarted and stalled sweeps");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
